// ===== design/timestamped_history_interpolator_assert.svh =====
// Assertion macros for the timestamped history interpolator.
// Included by the RTL files that carry concurrent assertions.
`ifndef TIMESTAMPED_HISTORY_INTERPOLATOR_ASSERT_SVH
`define TIMESTAMPED_HISTORY_INTERPOLATOR_ASSERT_SVH
`ifndef ASSERT_OFF
// Check an implication at every clock edge outside reset.
`define THI_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check that a condition leads to another one in the following cycle.
`define THI_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define THI_ASSERT(lbl, clk, rst_n, prop, msg)
`define THI_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== design/thi_pkg.sv =====
// Shared types, constants and helpers for the timestamped history interpolator.
// No dependencies.
`default_nettype none
package thi_pkg;
	localparam int DEPTH_DEF = 32;
	localparam int FRAC_W    = 16;
	localparam int VEC_N     = 6;

	typedef enum logic [1:0] {
		OP_ADD   = 2'd0,
		OP_FILL  = 2'd1,
		OP_QUERY = 2'd2,
		OP_SHIFT = 2'd3
	} op_t;

	typedef enum logic [3:0] {
		ST_CLEAR, ST_IDLE, ST_FILL, ST_SHIFT, ST_SHEND,
		ST_QRD, ST_QCHK, ST_QVB, ST_QVN, ST_QCAP,
		ST_QFRAC, ST_QDIV, ST_QMUL, ST_QADD, ST_QOUT
	} state_t;

	typedef struct packed {
		op_t                op;
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
		logic signed [31:0] aux_x;
		logic signed [31:0] aux_y;
		logic signed [31:0] aux_z;
		logic        [31:0] stamp;
	} in_t;

	typedef struct packed {
		logic signed [31:0] out_pos_x;
		logic signed [31:0] out_pos_y;
		logic signed [31:0] out_pos_z;
		logic signed [31:0] out_aux_x;
		logic signed [31:0] out_aux_y;
		logic signed [31:0] out_aux_z;
	} out_t;

	typedef struct packed {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
		logic signed [31:0] aux_x;
		logic signed [31:0] aux_y;
		logic signed [31:0] aux_z;
	} vec_t;

	localparam int VEC_W = $bits(vec_t);

	// Pick one component of a stored vector
	function automatic logic signed [31:0] vec_get(input vec_t v, input logic [2:0] i);
		logic signed [31:0] r;
		case (i)
			3'd0: r = v.pos_x;
			3'd1: r = v.pos_y;
			3'd2: r = v.pos_z;
			3'd3: r = v.aux_x;
			3'd4: r = v.aux_y;
			3'd5: r = v.aux_z;
			default: r = '0;
		endcase
		return r;
	endfunction
endpackage
`default_nettype wire

// ===== design/thi_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`default_nettype none
module thi_ram #(
	parameter int W = 32,
	parameter int D = 32
) (
	input  wire logic                 clk,
	input  wire logic                 we,
	input  wire logic [$clog2(D)-1:0] waddr,
	input  wire logic [W-1:0]         wdata,
	input  wire logic [$clog2(D)-1:0] raddr,
	output logic      [W-1:0]         rdata
);
	logic [W-1:0] mem [D];

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

// ===== design/thi_div.sv =====
// Restoring divider for the Q0.16 fraction: quo = floor(num * 2^16 / den), num < den.
// Depends on thi_pkg.
`default_nettype none
module thi_div (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	input  wire logic [31:0]               num,
	input  wire logic [31:0]               den,
	output logic                           done,
	output logic [thi_pkg::FRAC_W-1:0]     quo
);
	import thi_pkg::*;

	logic [32:0]              rem_q;
	logic [31:0]              den_q;
	logic [FRAC_W-1:0]        quo_q;
	logic [$clog2(FRAC_W):0]  cnt_q;
	logic                     run_q;
	logic                     done_q;
	logic [32:0]              rem2;
	logic                     take;

	// One quotient bit per cycle
	always_comb begin
		rem2 = {rem_q[31:0], 1'b0};
		take = rem2 >= {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == ($clog2(FRAC_W)+1)'(FRAC_W - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Remainder and quotient shift registers
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= {1'b0, num};
			den_q <= den;
			quo_q <= '0;
		end else if (run_q) begin
			rem_q <= take ? (rem2 - {1'b0, den_q}) : rem2;
			quo_q <= {quo_q[FRAC_W-2:0], take};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;
endmodule
`default_nettype wire

// ===== design/timestamped_history_interpolator.sv =====
// Timestamped history ring with linear interpolation, held in two one-port-read RAMs.
// Operations: add, fill, shift (read-modify-write sweep) and query.
// Query: search back from the newest entry, then read both entries and form the fraction, run
// the divider when it is needed, do the six shared multiply-add steps and load the output.
// After reset the RAMs are cleared in a pass over all DEPTH entries; no transaction is taken then.
`default_nettype none
module timestamped_history_interpolator #(
	parameter int DEPTH = thi_pkg::DEPTH_DEF
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_ready,
	input  wire thi_pkg::in_t    in_data,
	output logic                 out_valid,
	input  wire logic            out_ready,
	output thi_pkg::out_t        out_data
);
	import thi_pkg::*;
	`include "timestamped_history_interpolator_assert.svh"

	localparam int AW = $clog2(DEPTH);
	localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

	state_t              state_q, state_d;
	logic [AW-1:0]       cnt_q, wp_q, idx_q, base_q, next_idx;
	in_t                 req_q;
	logic [31:0]         sb_q, sn_q;
	vec_t                va_q, vb_q;
	logic [FRAC_W:0]     f_q;
	logic [2:0]          c_q;
	logic signed [50:0]  prod_s1;
	logic signed [31:0]  res_q [VEC_N];
	out_t                out_q;
	logic                out_vld_q;
	logic                sh_vld_s1;
	logic [AW-1:0]       sh_addr_s1;

	logic                vec_we, st_we;
	logic [AW-1:0]       vec_waddr, st_waddr, vec_raddr, st_raddr;
	vec_t                vec_wdata, vec_rdata, vec_in, vec_fill, vec_shift;
	logic [31:0]         st_wdata, st_rdata;
	logic                div_start, div_done, out_load, hit;
	logic [FRAC_W-1:0]   div_quo;
	logic signed [32:0]  num, den, num_m, den_m;
	logic [FRAC_W:0]     f_direct;
	logic signed [31:0]  comp_a, comp_b;
	logic signed [32:0]  diff;

	// Entry data for add, fill and shift; next entry index and search hit for queries
	always_comb begin
		vec_in   = '{in_data.pos_x, in_data.pos_y, in_data.pos_z,
			in_data.aux_x, in_data.aux_y, in_data.aux_z};
		vec_fill = '{req_q.pos_x, req_q.pos_y, req_q.pos_z,
			req_q.pos_x, req_q.pos_y, req_q.pos_z};
		vec_shift = vec_rdata;
		vec_shift.pos_x = vec_rdata.pos_x + req_q.pos_x;
		vec_shift.pos_y = vec_rdata.pos_y + req_q.pos_y;
		vec_shift.pos_z = vec_rdata.pos_z + req_q.pos_z;
		next_idx = (base_q == LAST) ? '0 : base_q + 1'b1;
		hit = (st_rdata <= req_q.stamp) || (idx_q == wp_q);
	end

	// Fraction: signed differences, sign fold and clamps
	always_comb begin
		num   = $signed({1'b0, req_q.stamp}) - $signed({1'b0, sb_q});
		den   = $signed({1'b0, sn_q}) - $signed({1'b0, sb_q});
		num_m = den[32] ? -num : num;
		den_m = den[32] ? -den : den;
		f_direct = '0;
		div_start = 1'b0;
		if (den != '0 && !num_m[32] && num_m != '0) begin
			if (num_m >= den_m) begin
				f_direct = (FRAC_W+1)'(1 << FRAC_W);
			end else begin
				div_start = (state_q == ST_QFRAC);
			end
		end
	end

	thi_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (num_m[31:0]),
		.den    (den_m[31:0]),
		.done   (div_done),
		.quo    (div_quo)
	);

	// Component select and difference for the shared multiply
	always_comb begin
		comp_a = vec_get(va_q, c_q);
		comp_b = vec_get(vb_q, c_q);
		diff   = {comp_b[31], comp_b} - {comp_a[31], comp_a};
	end

	// Next state and RAM port control
	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		vec_we    = 1'b0;
		vec_waddr = cnt_q;
		vec_wdata = '0;
		st_we     = 1'b0;
		st_waddr  = cnt_q;
		st_wdata  = '0;
		vec_raddr = cnt_q;
		st_raddr  = idx_q;
		out_load  = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				vec_we = 1'b1;
				st_we  = 1'b1;
				if (cnt_q == LAST) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					case (in_data.op)
						OP_ADD: begin
							vec_we    = 1'b1;
							vec_waddr = wp_q;
							vec_wdata = vec_in;
							st_we     = 1'b1;
							st_waddr  = wp_q;
							st_wdata  = in_data.stamp;
						end
						OP_FILL:  state_d = ST_FILL;
						OP_SHIFT: state_d = ST_SHIFT;
						OP_QUERY: state_d = ST_QRD;
						default:  state_d = ST_IDLE;
					endcase
				end
			end
			ST_FILL: begin
				vec_we    = 1'b1;
				vec_wdata = vec_fill;
				if (cnt_q == LAST) begin
					state_d = ST_IDLE;
				end
			end
			ST_SHIFT: begin
				if (cnt_q == LAST) begin
					state_d = ST_SHEND;
				end
			end
			ST_SHEND: state_d = ST_IDLE;
			ST_QRD:   state_d = ST_QCHK;
			ST_QCHK:  state_d = hit ? ST_QVB : ST_QRD;
			ST_QVB: begin
				vec_raddr = base_q;
				state_d   = ST_QVN;
			end
			ST_QVN: begin
				vec_raddr = next_idx;
				st_raddr  = next_idx;
				state_d   = ST_QCAP;
			end
			ST_QCAP:  state_d = ST_QFRAC;
			ST_QFRAC: state_d = div_start ? ST_QDIV : ST_QMUL;
			ST_QDIV: begin
				if (div_done) begin
					state_d = ST_QMUL;
				end
			end
			ST_QMUL:  state_d = ST_QADD;
			ST_QADD:  state_d = (c_q == 3'(VEC_N - 1)) ? ST_QOUT : ST_QMUL;
			ST_QOUT: begin
				if (!out_vld_q) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
		// write back the shifted entry whose read was issued in the previous cycle
		if (sh_vld_s1) begin
			vec_we    = 1'b1;
			vec_waddr = sh_addr_s1;
			vec_wdata = vec_shift;
		end
	end

	thi_ram #(.W(VEC_W), .D(DEPTH)) u_vec_ram (
		.clk   (clk),
		.we    (vec_we),
		.waddr (vec_waddr),
		.wdata (vec_wdata),
		.raddr (vec_raddr),
		.rdata (vec_rdata)
	);

	thi_ram #(.W(32), .D(DEPTH)) u_stamp_ram (
		.clk   (clk),
		.we    (st_we),
		.waddr (st_waddr),
		.wdata (st_wdata),
		.raddr (st_raddr),
		.rdata (st_rdata)
	);

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// Control registers: sweep counter, write pointer, shift stage, result flag, component index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q      <= '0;
			wp_q       <= '0;
			sh_vld_s1  <= 1'b0;
			sh_addr_s1 <= '0;
			out_vld_q  <= 1'b0;
			c_q        <= '0;
		end else begin
			if (state_q == ST_CLEAR || state_q == ST_FILL || state_q == ST_SHIFT) begin
				cnt_q <= (cnt_q == LAST) ? '0 : cnt_q + 1'b1;
			end
			if (state_q == ST_IDLE && in_valid && in_data.op == OP_ADD) begin
				wp_q <= (wp_q == LAST) ? '0 : wp_q + 1'b1;
			end
			sh_vld_s1  <= (state_q == ST_SHIFT);
			sh_addr_s1 <= cnt_q;
			if (out_load) begin
				out_vld_q <= 1'b1;
			end else if (out_ready) begin
				out_vld_q <= 1'b0;
			end
			if (state_q == ST_QFRAC) begin
				c_q <= '0;
			end else if (state_q == ST_QADD) begin
				c_q <= c_q + 1'b1;
			end
		end
	end

	// Query datapath registers
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) begin
			req_q <= in_data;
			idx_q <= (wp_q == '0) ? LAST : wp_q - 1'b1;
		end
		if (state_q == ST_QCHK) begin
			if (hit) begin
				base_q <= idx_q;
				sb_q   <= st_rdata;
			end else begin
				idx_q <= (idx_q == '0) ? LAST : idx_q - 1'b1;
			end
		end
		if (state_q == ST_QVN) begin
			va_q <= vec_rdata;
		end
		if (state_q == ST_QCAP) begin
			vb_q <= vec_rdata;
			sn_q <= st_rdata;
		end
		if (state_q == ST_QFRAC) begin
			f_q <= f_direct;
		end else if (state_q == ST_QDIV && div_done) begin
			f_q <= {1'b0, div_quo};
		end
		if (state_q == ST_QMUL) begin
			prod_s1 <= diff * $signed({1'b0, f_q});
		end
		if (state_q == ST_QADD) begin
			res_q[c_q] <= comp_a + prod_s1[47:16];
		end
		if (out_load) begin
			out_q <= '{res_q[0], res_q[1], res_q[2], res_q[3], res_q[4], res_q[5]};
		end
	end

	assign out_valid = out_vld_q;
	assign out_data  = out_q;

	`THI_ASSERT(a_wp_range, clk, arst_n, wp_q <= LAST, "write pointer out of range")
	`THI_ASSERT(a_shift_addr, clk, arst_n, (sh_vld_s1 && state_q == ST_SHIFT) |-> (sh_addr_s1 != cnt_q), "shift write collides with read")
	`THI_ASSERT(a_no_overwrite, clk, arst_n, out_load |-> !out_vld_q, "pending result overwritten")
	`THI_ASSERT(a_comp_range, clk, arst_n, (state_q == ST_QMUL || state_q == ST_QADD) |-> (c_q < 3'(VEC_N)), "component index out of range")
	`THI_ASSERT_NEXT(a_div_wait, clk, arst_n, div_start, state_q == ST_QDIV, "divider started outside wait")
endmodule
`default_nettype wire

// ===== tb/sv/tb.sv =====
// Self-checking testbench for timestamped_history_interpolator: directed table, then random
// traffic, every query checked against a table value or an in-bench predictor of the history ring.
// Depends on thi_pkg and the RTL of the block only.
`default_nettype none
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import thi_pkg::*;

	localparam int RING = DEPTH_DEF;

	typedef struct {
		in_t  item;
		bit   typed;
		out_t want;
	} row_t;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	in_t  in_data;
	logic out_valid;
	logic out_ready;
	out_t out_data;

	timestamped_history_interpolator dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);

	// predictor copy of the ring
	vec_t        ring_vec[RING];
	logic [31:0] ring_stamp[RING];
	logic [4:0]  ring_wp;

	out_t pending_q[$];
	row_t rows[$];
	int   fails;
	int   n_items;
	int   n_queries;
	int   n_checked;
	bit   calm;
	bit   hold_req;
	logic [31:0] clock_now;

	// clock
	initial clk = 1'b0;
	always #5 clk = ~clk;

	// lerp one component with floor rounding, as the block does
	function automatic logic [31:0] lerp(input logic [31:0] a, input logic [31:0] b,
			input longint f);
		longint sa;
		longint sb;
		longint p;
		longint q;
		sa = longint'($signed(a));
		sb = longint'($signed(b));
		p = (sb - sa) * f;
		if (p >= 0)
			q = p / 65536;
		else
			q = -((-p + 65535) / 65536);
		return 32'(sa + q);
	endfunction

	// search back from the newest entry and interpolate towards the next one
	function automatic out_t interpolate(input logic [31:0] t);
		logic [4:0] base;
		logic [4:0] idx;
		logic [4:0] nxt;
		longint num;
		longint den;
		longint f;
		out_t r;
		base = ring_wp;
		for (int k = 0; k < RING; k++) begin
			idx = ring_wp - 5'd1 - 5'(k);
			base = idx;
			if (ring_stamp[idx] <= t || idx == ring_wp)
				break;
		end
		nxt = base + 5'd1;
		num = longint'({32'd0, t}) - longint'({32'd0, ring_stamp[base]});
		den = longint'({32'd0, ring_stamp[nxt]}) - longint'({32'd0, ring_stamp[base]});
		if (den < 0) begin
			num = -num;
			den = -den;
		end
		if (den == 0 || num <= 0)
			f = 0;
		else if (num >= den)
			f = 65536;
		else
			f = (num * 65536) / den;
		r.out_pos_x = lerp(ring_vec[base].pos_x, ring_vec[nxt].pos_x, f);
		r.out_pos_y = lerp(ring_vec[base].pos_y, ring_vec[nxt].pos_y, f);
		r.out_pos_z = lerp(ring_vec[base].pos_z, ring_vec[nxt].pos_z, f);
		r.out_aux_x = lerp(ring_vec[base].aux_x, ring_vec[nxt].aux_x, f);
		r.out_aux_y = lerp(ring_vec[base].aux_y, ring_vec[nxt].aux_y, f);
		r.out_aux_z = lerp(ring_vec[base].aux_z, ring_vec[nxt].aux_z, f);
		return r;
	endfunction

	// advance the predicted ring by one transaction; queue the result of a query
	task automatic apply_item(input in_t it, input bit typed, input out_t want);
		case (it.op)
			OP_ADD: begin
				ring_vec[ring_wp] = '{it.pos_x, it.pos_y, it.pos_z, it.aux_x, it.aux_y,
					it.aux_z};
				ring_stamp[ring_wp] = it.stamp;
				ring_wp = ring_wp + 5'd1;
			end
			OP_FILL: begin
				for (int k = 0; k < RING; k++)
					ring_vec[k] = '{it.pos_x, it.pos_y, it.pos_z, it.pos_x, it.pos_y,
						it.pos_z};
			end
			OP_SHIFT: begin
				for (int k = 0; k < RING; k++) begin
					ring_vec[k].pos_x = ring_vec[k].pos_x + it.pos_x;
					ring_vec[k].pos_y = ring_vec[k].pos_y + it.pos_y;
					ring_vec[k].pos_z = ring_vec[k].pos_z + it.pos_z;
				end
			end
			default: begin
				n_queries++;
				pending_q.push_back(typed ? want : interpolate(it.stamp));
			end
		endcase
	endtask

	// offer one transaction, idling first at random; returns at the accepting edge
	task automatic send(input in_t it, input bit typed, input out_t want);
		if (!calm && $urandom_range(0, 99) < 23) begin
			in_valid <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(0, 99) < 23);
		end
		in_data  <= it;
		in_valid <= 1'b1;
		do
			@(negedge clk);
		while (!in_ready);
		@(posedge clk);
		n_items++;
		apply_item(it, typed, want);
	endtask

	function automatic logic [31:0] pick32();
		case ($urandom_range(0, 7))
			0: return 32'h0000_0000;
			1: return 32'h7fff_ffff;
			2: return 32'h8000_0000;
			3: return 32'hffff_ffff;
			default: return $urandom;
		endcase
	endfunction

	function automatic in_t mk(input op_t op, input logic [31:0] px, input logic [31:0] py,
			input logic [31:0] pz, input logic [31:0] ax, input logic [31:0] ay,
			input logic [31:0] az, input logic [31:0] t);
		in_t it;
		it.op = op;
		it.pos_x = px; it.pos_y = py; it.pos_z = pz;
		it.aux_x = ax; it.aux_y = ay; it.aux_z = az;
		it.stamp = t;
		return it;
	endfunction

	task automatic row(input in_t it, input bit typed, input out_t want);
		row_t r;
		r.item = it;
		r.typed = typed;
		r.want = want;
		rows.push_back(r);
	endtask

	task automatic cmp(input string name, input logic [31:0] want, input logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected %h, got %h", name, want, got);
			fails++;
		end
	endtask

	// receiver: random back-pressure, one long hold-off on request
	initial begin
		out_ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				out_ready <= 1'b0;
				repeat (400) @(posedge clk);
			end else begin
				out_ready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 23);
			end
		end
	end

	// check each result transaction against the oldest expectation
	always @(negedge clk) begin
		out_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_q.size() == 0) begin
				$error("result with no query outstanding: %h", out_data);
				fails++;
			end else begin
				want = pending_q.pop_front();
				n_checked++;
				cmp("out_pos_x", want.out_pos_x, out_data.out_pos_x);
				cmp("out_pos_y", want.out_pos_y, out_data.out_pos_y);
				cmp("out_pos_z", want.out_pos_z, out_data.out_pos_z);
				cmp("out_aux_x", want.out_aux_x, out_data.out_aux_x);
				cmp("out_aux_y", want.out_aux_y, out_data.out_aux_y);
				cmp("out_aux_z", want.out_aux_z, out_data.out_aux_z);
			end
		end
	end

	// overall time limit
	initial begin
		#20ms;
		$display("TB_ERROR");
		$finish;
	end

	// main sequence
	initial begin
		out_t zero;
		out_t w;
		in_t  it;
		int   sel;
		fails = 0; n_items = 0; n_queries = 0; n_checked = 0;
		calm = 1'b0; hold_req = 1'b0;
		zero = '0;
		ring_wp = '0;
		for (int k = 0; k < RING; k++) begin
			ring_vec[k] = '0;
			ring_stamp[k] = '0;
		end
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table: empty ring, fill, shift wrap, extremes, wrap-around, equal times
		row(mk(OP_QUERY, 1, 2, 3, 4, 5, 6, 32'h0), 1, zero);
		row(mk(OP_QUERY, 0, 0, 0, 0, 0, 0, 32'hffff_ffff), 1, zero);
		row(mk(OP_FILL, 32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff, 32'h1234_5678,
			32'hdead_beef, 32'h5555_5555, 32'haaaa_aaaa), 0, zero);
		w = '{32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff, 32'h7fff_ffff, 32'h8000_0000,
			32'hffff_ffff};
		row(mk(OP_QUERY, 0, 0, 0, 0, 0, 0, 32'd123), 1, w);
		row(mk(OP_SHIFT, 32'h1, 32'hffff_ffff, 32'h8000_0000, 32'hffff_ffff, 32'h0, 32'h1,
			32'hffff_ffff), 0, zero);
		w = '{32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000,
			32'hffff_ffff};
		row(mk(OP_QUERY, 0, 0, 0, 0, 0, 0, 32'd77), 1, w);
		row(mk(OP_ADD, 32'h7fff_ffff, 32'h8000_0000, 32'h0, 32'h8000_0000, 32'h7fff_ffff,
			32'hffff_ffff, 32'd1000), 0, zero);
		row(mk(OP_ADD, 32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff, 32'h7fff_ffff,
			32'h8000_0000, 32'h0, 32'd2000), 0, zero);
		row(mk(OP_QUERY, 0, 0, 0, 0, 0, 0, 32'd1500), 0, zero);
		row(mk(OP_QUERY, 0, 0, 0, 0, 0, 0, 32'd500), 0, zero);
		row(mk(OP_QUERY, 0, 0, 0, 0, 0, 0, 32'd3000), 0, zero);
		row(mk(OP_ADD, 32'h0001_0000, 32'hffff_0000, 32'h5555_5555, 32'haaaa_aaaa, 32'h1,
			32'h0, 32'd2000), 0, zero);
		row(mk(OP_QUERY, 0, 0, 0, 0, 0, 0, 32'd2000), 0, zero);
		row(mk(OP_QUERY, 0, 0, 0, 0, 0, 0, 32'd1999), 0, zero);
		row(mk(OP_QUERY, 0, 0, 0, 0, 0, 0, 32'hffff_ffff), 0, zero);
		row(mk(OP_QUERY, 0, 0, 0, 0, 0, 0, 32'h0), 0, zero);
		row(mk(OP_SHIFT, 32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff, 0, 0, 0, 0), 0, zero);
		row(mk(OP_QUERY, 0, 0, 0, 0, 0, 0, 32'd1250), 0, zero);
		row(mk(OP_ADD, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
			32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff), 0, zero);
		row(mk(OP_QUERY, 0, 0, 0, 0, 0, 0, 32'hffff_fffe), 0, zero);
		row(mk(OP_QUERY, 0, 0, 0, 0, 0, 0, 32'hffff_ffff), 0, zero);
		foreach (rows[i])
			send(rows[i].item, rows[i].typed, rows[i].want);

		// random traffic: rising snapshot times with queries around the window
		clock_now = 32'd5000;
		for (int n = 0; n < 1280; n++) begin
			calm = (n >= 500 && n < 650);
			if (n == 250)
				hold_req = 1'b1;
			sel = $urandom_range(0, 99);
			it = mk(OP_ADD, pick32(), pick32(), pick32(), pick32(), pick32(), pick32(),
				$urandom);
			if (sel < 40) begin
				clock_now = clock_now + (($urandom_range(0, 9) == 0) ? 32'd0 :
					$urandom_range(1, 400));
				it.stamp = clock_now;
			end else if (sel < 75 || (n >= 250 && n < 300)) begin
				it.op = OP_QUERY;
				case ($urandom_range(0, 5))
					0: it.stamp = $urandom;
					1: it.stamp = clock_now + $urandom_range(0, 500);
					default: it.stamp = clock_now - $urandom_range(0, 12000);
				endcase
			end else if (sel < 83) begin
				it.op = OP_SHIFT;
			end else if (sel < 88) begin
				it.op = OP_FILL;
			end else begin
				it.op = op_t'($urandom_range(0, 3));
			end
			send(it, 0, zero);
		end
		in_valid <= 1'b0;
		calm = 1'b0;

		// drain, then let a trailing shift or fill finish
		while (pending_q.size() != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);

		$display("Sent %0d transactions, %0d of them queries; %0d results checked.",
			n_items, n_queries, n_checked);
		if (fails == 0 && pending_q.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end
endmodule
`default_nettype wire
